### rtl/http_response_head_tokenizer_top_macros.svh
// Assertion macros for the HTTP response head tokenizer.
`ifndef HTTP_RESPONSE_HEAD_TOKENIZER_TOP_MACROS_SVH
`define HTTP_RESPONSE_HEAD_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define HRHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define HRHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hrht_pkg.sv
// Package with tag codes and character constants of the HTTP response head tokenizer.
`timescale 1ns / 1ps

package hrht_pkg;

  localparam logic [3:0] TAG_VERSION_CHAR = 4'd0;
  localparam logic [3:0] TAG_VERSION_END  = 4'd1;
  localparam logic [3:0] TAG_CODE_DONE    = 4'd2;
  localparam logic [3:0] TAG_REASON_CHAR  = 4'd3;
  localparam logic [3:0] TAG_REASON_END   = 4'd4;
  localparam logic [3:0] TAG_NAME_CHAR    = 4'd5;
  localparam logic [3:0] TAG_NAME_END     = 4'd6;
  localparam logic [3:0] TAG_VALUE_CHAR   = 4'd7;
  localparam logic [3:0] TAG_HEADER_END   = 4'd8;
  localparam logic [3:0] TAG_BODY_BYTE    = 4'd9;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [15:0] CODE_MAX = 16'hFFFF;

endpackage

### rtl/http_response_head_tokenizer_top.sv
// Top level of the HTTP response head tokenizer: byte tagging state machine.
//
// Usage: one response byte enters per item on the input channel (byte_in,
// restart; in_valid/in_stall). Each byte yields zero or one tagged item on the
// output channel (tag, data, status_code; out_valid/out_stall). restart set
// returns the parser to the version phase and drops the byte with no result.
// Pipeline: an accepted item passes two register stages, an input register and
// then the result register, before its result shows.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single state update between the input register and the result register.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more byte; in_stall rises only once both are full.
// Reset (rst, synchronous): both stages empty, parser in the version phase,
// status code accumulator and line flags cleared.
`timescale 1ns / 1ps
`include "http_response_head_tokenizer_top_macros.svh"

module http_response_head_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  tag,
  output logic [7:0]  data,
  output logic [15:0] status_code
);

  localparam logic [2:0] PH_VERSION = 3'd0;
  localparam logic [2:0] PH_CODE    = 3'd1;
  localparam logic [2:0] PH_REASON  = 3'd2;
  localparam logic [2:0] PH_HEADER  = 3'd3;
  localparam logic [2:0] PH_BODY    = 3'd4;

  // input register
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_restart;

  // parser state
  logic [2:0]  phase, phase_next;
  logic [15:0] code_value, code_value_next;
  logic        code_started, code_started_next;
  logic        code_digits_stopped, code_digits_stopped_next;
  logic        line_nonempty, line_nonempty_next;
  logic        colon_seen, colon_seen_next;
  logic        value_started, value_started_next;

  // result of the current item
  logic        res_valid;
  logic [3:0]  res_tag;
  logic [7:0]  res_data;
  logic [15:0] res_code;

  logic        advance;
  logic        is_digit;
  logic [3:0]  digit;
  logic [19:0] code_acc;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;

  assign is_digit = (in_q_byte >= hrht_pkg::CH_ZERO) && (in_q_byte <= hrht_pkg::CH_NINE);
  assign digit    = 4'(in_q_byte - hrht_pkg::CH_ZERO);
  assign code_acc = ({4'b0, code_value} << 3) + ({4'b0, code_value} << 1) + {16'b0, digit};

  always_comb begin
    phase_next               = phase;
    code_value_next          = code_value;
    code_started_next        = code_started;
    code_digits_stopped_next = code_digits_stopped;
    line_nonempty_next       = line_nonempty;
    colon_seen_next          = colon_seen;
    value_started_next       = value_started;
    res_valid                = 1'b0;
    res_tag                  = hrht_pkg::TAG_BODY_BYTE;
    res_data                 = 8'd0;
    res_code                 = 16'd0;
    if (in_q_restart) begin
      phase_next               = PH_VERSION;
      code_value_next          = 16'd0;
      code_started_next        = 1'b0;
      code_digits_stopped_next = 1'b0;
      line_nonempty_next       = 1'b0;
      colon_seen_next          = 1'b0;
      value_started_next       = 1'b0;
    end else begin
      case (phase)
        PH_VERSION: begin
          res_valid = 1'b1;
          if (in_q_byte == hrht_pkg::CH_SP) begin
            phase_next               = PH_CODE;
            code_value_next          = 16'd0;
            code_started_next        = 1'b0;
            code_digits_stopped_next = 1'b0;
            res_tag                  = hrht_pkg::TAG_VERSION_END;
          end else begin
            res_tag  = hrht_pkg::TAG_VERSION_CHAR;
            res_data = in_q_byte;
          end
        end
        PH_CODE: begin
          if (in_q_byte == hrht_pkg::CH_SP) begin
            if (code_started) begin
              phase_next = PH_REASON;
              res_valid  = 1'b1;
              res_tag    = hrht_pkg::TAG_CODE_DONE;
              res_code   = code_value;
            end
          end else begin
            code_started_next = 1'b1;
            if (!code_digits_stopped) begin
              if (is_digit) begin
                code_value_next = (code_acc > {4'b0, hrht_pkg::CODE_MAX}) ?
                                  hrht_pkg::CODE_MAX : code_acc[15:0];
              end else begin
                code_digits_stopped_next = 1'b1;
              end
            end
          end
        end
        PH_REASON: begin
          if (in_q_byte == hrht_pkg::CH_LF) begin
            phase_next         = PH_HEADER;
            line_nonempty_next = 1'b0;
            colon_seen_next    = 1'b0;
            value_started_next = 1'b0;
            res_valid          = 1'b1;
            res_tag            = hrht_pkg::TAG_REASON_END;
          end else if (in_q_byte != hrht_pkg::CH_CR) begin
            res_valid = 1'b1;
            res_tag   = hrht_pkg::TAG_REASON_CHAR;
            res_data  = in_q_byte;
          end
        end
        PH_HEADER: begin
          if (in_q_byte == hrht_pkg::CH_LF) begin
            if (!line_nonempty) begin
              phase_next = PH_BODY;
            end else begin
              line_nonempty_next = 1'b0;
              colon_seen_next    = 1'b0;
              value_started_next = 1'b0;
              res_valid          = 1'b1;
              res_tag            = hrht_pkg::TAG_HEADER_END;
            end
          end else if (in_q_byte != hrht_pkg::CH_CR) begin
            line_nonempty_next = 1'b1;
            if (!colon_seen) begin
              res_valid = 1'b1;
              if (in_q_byte == hrht_pkg::CH_COLON) begin
                colon_seen_next = 1'b1;
                res_tag         = hrht_pkg::TAG_NAME_END;
              end else begin
                res_tag  = hrht_pkg::TAG_NAME_CHAR;
                res_data = in_q_byte;
              end
            end else if (value_started || (in_q_byte != hrht_pkg::CH_SP)) begin
              value_started_next = 1'b1;
              res_valid          = 1'b1;
              res_tag            = hrht_pkg::TAG_VALUE_CHAR;
              res_data           = in_q_byte;
            end
          end
        end
        default: begin
          res_valid = 1'b1;
          res_tag   = hrht_pkg::TAG_BODY_BYTE;
          res_data  = in_q_byte;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid          <= 1'b0;
      out_valid           <= 1'b0;
      phase               <= PH_VERSION;
      code_value          <= 16'd0;
      code_started        <= 1'b0;
      code_digits_stopped <= 1'b0;
      line_nonempty       <= 1'b0;
      colon_seen          <= 1'b0;
      value_started       <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_q_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= in_q_valid && res_valid;
      end
      if (in_q_valid && advance) begin
        phase               <= phase_next;
        code_value          <= code_value_next;
        code_started        <= code_started_next;
        code_digits_stopped <= code_digits_stopped_next;
        line_nonempty       <= line_nonempty_next;
        colon_seen          <= colon_seen_next;
        value_started       <= value_started_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte    <= byte_in;
      in_q_restart <= restart;
    end
    if (advance) begin
      tag         <= res_tag;
      data        <= res_data;
      status_code <= res_code;
    end
  end

  `HRHT_ASSERT_NEXT(a_held_item_kept, in_q_valid && !advance, in_q_valid, "held item lost")

  `HRHT_ASSERT_NOW(a_code_only_on_done, out_valid && (tag != hrht_pkg::TAG_CODE_DONE), status_code == 16'd0, "status code outside code done")

  `HRHT_ASSERT_NEXT(a_body_sticky, (phase == PH_BODY) && !(in_q_valid && in_q_restart), phase == PH_BODY, "body phase left without restart")

  `HRHT_ASSERT_NEXT(a_restart_to_version, in_q_valid && in_q_restart && advance, (phase == PH_VERSION) && (code_value == 16'd0), "restart did not clear parser")

endmodule
